/* rtl/sidc_pkg.sv */
// Shared types and constants of the sigmoid inverse depth converter.
// Holds the fixed-point constants, the reciprocal table of the series and codes.
// No dependencies.
`default_nettype none

package sidc_pkg;

    typedef struct packed {
        logic neg;
        logic last;
    } side_t;

    localparam int CODE_W    = 16;
    localparam int SCALE_W   = 32;
    localparam int DEPTH_W   = 24;
    localparam int XMAG_W    = 23;
    localparam int EXP_W     = 33;
    localparam int LOGI_NUM_W = 49;
    localparam int LOGI_DEN_W = 34;
    localparam int SIG_W     = 17;
    localparam int Q_W       = 36;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd16777216;
    localparam logic [30:0]        LOG2E_Q30   = 31'd1549082005;
    localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
    localparam logic [Q_W-1:0]     C009_Q32    = 36'd38654706;
    localparam logic [XMAG_W-1:0]  X_MAG_MAX   = 23'h7FFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 24'hFFFFFF;
    localparam logic [EXP_W-1:0]   EXP_ONE     = 33'h1_0000_0000;

    localparam int TAYLOR_TERMS = 12;
    localparam int CHAIN_LEN    = TAYLOR_TERMS - 1;

    // Truncated 2^32 / k for the series terms k = 2 .. 12.
    localparam logic [31:0] RECIP_Q32 [2:12] = '{
        32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
        32'd715827882,  32'd613566756,  32'd536870912,  32'd477218588,
        32'd429496729,  32'd390451572,  32'd357913941
    };

endpackage

`default_nettype wire

/* rtl/sidc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Rounds nothing itself; the caller adds half the divisor to the numerator.
// Depends on nothing but the clock enable given by the top level.
`default_nettype none

module sidc_div_pipe #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 34,
    parameter int QUO_W = 17
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    output logic                  out_valid,
    output logic                  out_last,
    output logic [QUO_W-1:0]      out_quo
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic             v_reg   [QUO_W];
    logic             l_reg   [QUO_W];

    logic [DEN_W-1:0] rem_in [QUO_W];
    logic [QUO_W-1:0] low_in [QUO_W];
    logic [QUO_W-1:0] quo_in [QUO_W];
    logic [DEN_W-1:0] den_in [QUO_W];
    logic             v_in   [QUO_W];
    logic             l_in   [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (g == 0) begin : g_first
            assign rem_in[g] = DEN_W'(in_num >> QUO_W);
            assign low_in[g] = in_num[QUO_W-1:0];
            assign quo_in[g] = '0;
            assign den_in[g] = in_den;
            assign v_in[g]   = in_valid;
            assign l_in[g]   = in_last;
        end else begin : g_next
            assign rem_in[g] = rem_reg[g-1];
            assign low_in[g] = low_reg[g-1];
            assign quo_in[g] = quo_reg[g-1];
            assign den_in[g] = den_reg[g-1];
            assign v_in[g]   = v_reg[g-1];
            assign l_in[g]   = l_reg[g-1];
        end

        assign trial    = {rem_in[g], low_in[g][QUO_W-1]};
        assign diff     = trial - {1'b0, den_in[g]};
        assign ge       = trial >= {1'b0, den_in[g]};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= rem_next;
                low_reg[g] <= {low_in[g][QUO_W-2:0], 1'b0};
                quo_reg[g] <= {quo_in[g][QUO_W-2:0], ge};
                den_reg[g] <= den_in[g];
                l_reg[g]   <= l_in[g];
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_last  = l_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

/* rtl/sidc_exp_pipe.sv */
// Pipelined exp(-x) in Q1.32 for x in Q7.16: range reduction by log2(e),
// then a twelve-term Taylor series with three register stages per term.
// Depends on sidc_pkg.
`default_nettype none

module sidc_exp_pipe
    import sidc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire side_t             in_side,
    input  wire logic [XMAG_W-1:0] in_xmag,
    output logic                   out_valid,
    output side_t                  out_side,
    output logic [EXP_W-1:0]       out_e
);

    logic [53:0] t_next;
    logic [7:0]  n0_reg;
    logic [31:0] f0_reg;
    logic        v0_reg;
    side_t       s0_reg;

    logic [63:0] r_prod;
    logic [31:0] r1_reg;
    logic [7:0]  n1_reg;
    logic        v1_reg;
    side_t       s1_reg;

    assign t_next = 54'(in_xmag) * 54'(LOG2E_Q30);
    assign r_prod = 64'(f0_reg) * 64'(LN2_Q32);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n0_reg <= t_next[53:46];
            f0_reg <= t_next[45:14];
            s0_reg <= in_side;
            r1_reg <= r_prod[63:32];
            n1_reg <= n0_reg;
            s1_reg <= s0_reg;
        end
    end

    logic [31:0]      pa_reg   [CHAIN_LEN];
    logic [EXP_W-1:0] suma_reg [CHAIN_LEN];
    logic [31:0]      ra_reg   [CHAIN_LEN];
    logic [7:0]       na_reg   [CHAIN_LEN];
    logic             va_reg   [CHAIN_LEN];
    side_t            sa_reg   [CHAIN_LEN];

    logic [31:0]      mb_reg   [CHAIN_LEN];
    logic [31:0]      pb_reg   [CHAIN_LEN];
    logic [EXP_W-1:0] sumb_reg [CHAIN_LEN];
    logic [31:0]      rb_reg   [CHAIN_LEN];
    logic [7:0]       nb_reg   [CHAIN_LEN];
    logic             vb_reg   [CHAIN_LEN];
    side_t            sb_reg   [CHAIN_LEN];

    logic [31:0]      tc_reg   [CHAIN_LEN];
    logic [EXP_W-1:0] sumc_reg [CHAIN_LEN];
    logic [31:0]      rc_reg   [CHAIN_LEN];
    logic [7:0]       nc_reg   [CHAIN_LEN];
    logic             vc_reg   [CHAIN_LEN];
    side_t            sc_reg   [CHAIN_LEN];

    logic [31:0]      term_in [CHAIN_LEN];
    logic [EXP_W-1:0] sum_in  [CHAIN_LEN];
    logic [31:0]      r_in    [CHAIN_LEN];
    logic [7:0]       n_in    [CHAIN_LEN];
    logic             v_in    [CHAIN_LEN];
    side_t            s_in    [CHAIN_LEN];

    for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_term
        localparam int          K     = g + 2;
        localparam logic        SUB   = (K % 2) == 0;
        localparam logic [31:0] RECIP = RECIP_Q32[K];

        logic [63:0]      prod_a;
        logic [63:0]      prod_b;
        logic [35:0]      q0k;
        logic [35:0]      rem;
        logic [EXP_W-1:0] sum_next;
        logic [31:0]      term_next;

        if (g == 0) begin : g_first
            assign term_in[g] = r1_reg;
            assign sum_in[g]  = EXP_ONE;
            assign r_in[g]    = r1_reg;
            assign n_in[g]    = n1_reg;
            assign v_in[g]    = v1_reg;
            assign s_in[g]    = s1_reg;
        end else begin : g_next
            assign term_in[g] = tc_reg[g-1];
            assign sum_in[g]  = sumc_reg[g-1];
            assign r_in[g]    = rc_reg[g-1];
            assign n_in[g]    = nc_reg[g-1];
            assign v_in[g]    = vc_reg[g-1];
            assign s_in[g]    = sc_reg[g-1];
        end

        // The previous term is folded into the sum while the next one is formed.
        assign prod_a   = 64'(term_in[g]) * 64'(r_in[g]);
        assign sum_next = SUB ? sum_in[g] - EXP_W'(term_in[g])
                              : sum_in[g] + EXP_W'(term_in[g]);

        // Division by K: reciprocal estimate is low by at most one.
        assign prod_b    = 64'(pa_reg[g]) * 64'(RECIP);
        assign q0k       = 36'(mb_reg[g]) * 36'(K);
        assign rem       = 36'(pb_reg[g]) - q0k;
        assign term_next = (rem >= 36'(K)) ? mb_reg[g] + 32'd1 : mb_reg[g];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg[g] <= 1'b0;
                vb_reg[g] <= 1'b0;
                vc_reg[g] <= 1'b0;
            end else if (en) begin
                va_reg[g] <= v_in[g];
                vb_reg[g] <= va_reg[g];
                vc_reg[g] <= vb_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[g]   <= prod_a[63:32];
                suma_reg[g] <= sum_next;
                ra_reg[g]   <= r_in[g];
                na_reg[g]   <= n_in[g];
                sa_reg[g]   <= s_in[g];

                mb_reg[g]   <= prod_b[63:32];
                pb_reg[g]   <= pa_reg[g];
                sumb_reg[g] <= suma_reg[g];
                rb_reg[g]   <= ra_reg[g];
                nb_reg[g]   <= na_reg[g];
                sb_reg[g]   <= sa_reg[g];

                tc_reg[g]   <= term_next;
                sumc_reg[g] <= sumb_reg[g];
                rc_reg[g]   <= rb_reg[g];
                nc_reg[g]   <= nb_reg[g];
                sc_reg[g]   <= sb_reg[g];
            end
        end
    end

    localparam logic FINAL_SUB = (TAYLOR_TERMS % 2) == 1;

    logic [EXP_W-1:0] sum_final;
    logic [EXP_W-1:0] e_next;
    logic [EXP_W-1:0] e_reg;
    logic             ve_reg;
    side_t            se_reg;

    assign sum_final = FINAL_SUB ? sumc_reg[CHAIN_LEN-1] - EXP_W'(tc_reg[CHAIN_LEN-1])
                                 : sumc_reg[CHAIN_LEN-1] + EXP_W'(tc_reg[CHAIN_LEN-1]);
    assign e_next    = (nc_reg[CHAIN_LEN-1] >= 8'd32) ? '0
                                                      : sum_final >> nc_reg[CHAIN_LEN-1][4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= vc_reg[CHAIN_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg  <= e_next;
            se_reg <= sc_reg[CHAIN_LEN-1];
        end
    end

    assign out_valid = ve_reg;
    assign out_side  = se_reg;
    assign out_e     = e_reg;

endmodule

`default_nettype wire

/* rtl/sigmoid_inverse_depth_convert.sv */
// Throughput: one pixel per cycle; every stage is a register, so the only limit is
// the output handshake, and a stall on m_tready freezes the whole pipeline in place.
// Reset (aresetn low at a clock edge) empties the pipeline and restores the
// zero point to 0 and the scale to 1.0. Depends on sidc_pkg, sidc_exp_pipe and
// sidc_div_pipe.
`default_nettype none

module sigmoid_inverse_depth_convert
    import sidc_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,    // [15:0] raw_code
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,    // [23:0] depth
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int QD_W     = OUT_FRAC_BITS + 7;
    localparam int NUMD_W   = OUT_FRAC_BITS + 33;
    localparam int DQ_EXT_W = (QD_W > DEPTH_W) ? QD_W : DEPTH_W;

    logic [CODE_W-1:0]  zero_point_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               en;

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_point_reg <= '0;
            scale_reg      <= SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ZERO_POINT: zero_point_reg <= cfg_data[CODE_W-1:0];
                REG_SCALE:      scale_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Dequantize: magnitude, scale product, rounding and saturation.
    logic              neg_next;
    logic [CODE_W-1:0] dmag_next;
    logic [CODE_W-1:0] dmag_reg;
    side_t             sa_reg;
    logic              va_reg;

    logic [47:0]       prod_next;
    logic [47:0]       prod_reg;
    side_t             sb_reg;
    logic              vb_reg;

    logic [48:0]       rnd_next;
    logic [XMAG_W-1:0] xmag_next;
    logic [XMAG_W-1:0] xmag_reg;
    side_t             sc_reg;
    logic              vc_reg;

    assign neg_next  = s_tdata < zero_point_reg;
    assign dmag_next = neg_next ? zero_point_reg - s_tdata : s_tdata - zero_point_reg;
    assign prod_next = 48'(dmag_reg) * 48'(scale_reg);
    assign rnd_next  = 49'(prod_reg) + 49'd128;
    assign xmag_next = (|rnd_next[48:31]) ? X_MAG_MAX : rnd_next[30:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_reg <= dmag_next;
            sa_reg   <= '{neg: neg_next, last: s_tlast};
            prod_reg <= prod_next;
            sb_reg   <= sa_reg;
            xmag_reg <= xmag_next;
            sc_reg   <= sb_reg;
        end
    end

    logic             ve;
    side_t            se;
    logic [EXP_W-1:0] e_val;

    sidc_exp_pipe u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vc_reg),
        .in_side   (sc_reg),
        .in_xmag   (xmag_reg),
        .out_valid (ve),
        .out_side  (se),
        .out_e     (e_val)
    );

    // Logistic: s = round(2^48 / den) or round(e * 2^16 / den), den = 2^32 + e.
    logic [LOGI_DEN_W-1:0] den_next;
    logic [LOGI_NUM_W-1:0] numl_next;
    logic [LOGI_DEN_W-1:0] den_reg;
    logic [LOGI_NUM_W-1:0] numl_reg;
    logic                  vl_reg;
    logic                  ll_reg;

    assign den_next  = LOGI_DEN_W'(EXP_ONE) + LOGI_DEN_W'(e_val);
    assign numl_next = se.neg ? (LOGI_NUM_W'(e_val) << 16) + LOGI_NUM_W'(den_next >> 1)
                              : (LOGI_NUM_W'(1) << 48) + LOGI_NUM_W'(den_next >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
        end else if (en) begin
            vl_reg <= ve;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg  <= den_next;
            numl_reg <= numl_next;
            ll_reg   <= se.last;
        end
    end

    logic             vs;
    logic             ls;
    logic [SIG_W-1:0] sig;

    sidc_div_pipe #(
        .NUM_W (LOGI_NUM_W),
        .DEN_W (LOGI_DEN_W),
        .QUO_W (SIG_W)
    ) u_div_logistic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vl_reg),
        .in_last   (ll_reg),
        .in_num    (numl_reg),
        .in_den    (den_reg),
        .out_valid (vs),
        .out_last  (ls),
        .out_quo   (sig)
    );

    // Depth: round(2^(32+OUT_FRAC_BITS) / (10 * s * 2^16 + 0.009 * 2^32)).
    logic [Q_W-1:0]    q_next;
    logic [NUMD_W-1:0] numd_next;
    logic [Q_W-1:0]    q_reg;
    logic [NUMD_W-1:0] numd_reg;
    logic              vd_reg;
    logic              ld_reg;

    assign q_next    = ((Q_W'(sig) * Q_W'(10)) << 16) + C009_Q32;
    assign numd_next = (NUMD_W'(1) << (32 + OUT_FRAC_BITS)) + NUMD_W'(q_next >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vs;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg    <= q_next;
            numd_reg <= numd_next;
            ld_reg   <= ls;
        end
    end

    logic            vq;
    logic            lq;
    logic [QD_W-1:0] dq;

    sidc_div_pipe #(
        .NUM_W (NUMD_W),
        .DEN_W (Q_W),
        .QUO_W (QD_W)
    ) u_div_depth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vd_reg),
        .in_last   (ld_reg),
        .in_num    (numd_reg),
        .in_den    (q_reg),
        .out_valid (vq),
        .out_last  (lq),
        .out_quo   (dq)
    );

    logic [DQ_EXT_W-1:0] dq_ext;
    logic [DEPTH_W-1:0]  depth_next;
    logic [DEPTH_W-1:0]  depth_reg;
    logic                m_tvalid_reg;
    logic                m_tlast_reg;

    assign dq_ext     = DQ_EXT_W'(dq);
    assign depth_next = (dq_ext > DQ_EXT_W'(DEPTH_MAX)) ? DEPTH_MAX : dq_ext[DEPTH_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vq;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            depth_reg   <= depth_next;
            m_tlast_reg <= lq;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = depth_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* rtl/sidc_checker.sv */
// Port-level checks of the sigmoid inverse depth converter, bound to its top level.
// Depends on sigmoid_inverse_depth_convert.
`default_nettype none

module sidc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Result changed while stalled.");

    a_take_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Request refused with an empty output register.");

    a_take_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> s_tready)
        else $error("Request refused while the output drains.");

    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("Result present right after reset.");

    a_depth_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 24'd0)
        else $error("Depth of zero delivered.");

endmodule

bind sigmoid_inverse_depth_convert sidc_checker u_sidc_checker (.*);

`default_nettype wire

/* verif/tb_sigmoid_inverse_depth_convert.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sigmoid_inverse_depth_convert: streams raw codes under
// several zero point and scale settings and checks each depth and tlast in order.
// Depends on sidc_pkg and the converter RTL.

module tb_sigmoid_inverse_depth_convert;
    import sidc_pkg::*;

    localparam int OUT_FRAC    = 16;
    localparam int LATENCY     = OUT_FRAC + 66;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 158;
    localparam int MAX_PRINTS  = 100;

    localparam logic [63:0] LOG2E_FX   = 64'd1549082005;
    localparam logic [63:0] LN2_FX     = 64'd2977044472;
    localparam logic [63:0] K009_FX    = 64'd38654706;
    localparam logic [63:0] XMAG_SAT   = 64'd8388607;
    localparam logic [63:0] DEPTH_SAT  = 64'd16777215;
    localparam int          SERIES_LEN = 12;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
    } pixel_t;

    typedef struct packed {
        logic [23:0] depth;
        logic        last;
    } depth_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;    // [15:0] raw_code
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;           // [23:0] depth
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    logic [15:0]     zp_model    = 16'd0;
    logic [31:0]     scale_model = 32'd16777216;
    pixel_t          pixel_q[$];
    depth_result_t   depth_expect_q[$];
    pixel_t          offered_px     = '0;
    bit              req_held       = 1'b0;
    bit              src_idle_en    = 1'b0;
    bit              snk_idle_en    = 1'b0;
    bit              long_hold_req  = 1'b0;
    int              src_gap_left   = 0;
    int              snk_stall_left = 0;
    int              hold_left      = 0;
    int              mismatch_count = 0;
    int              results_seen   = 0;
    int              cycle_count    = 0;

    sigmoid_inverse_depth_convert #(
        .OUT_FRAC_BITS(OUT_FRAC)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic logic [23:0] predict_depth(input logic [15:0] code);
        logic        below;
        logic [63:0] dmag;
        logic [63:0] xmag;
        logic [63:0] prod;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] red;
        logic [63:0] term;
        logic [63:0] series;
        logic [63:0] ex;
        logic [63:0] den;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] dep;
        int          k;
        below = code < zp_model;
        dmag  = below ? 64'(zp_model) - 64'(code) : 64'(code) - 64'(zp_model);
        xmag  = (dmag * 64'(scale_model) + 64'd128) >> 8;
        if (xmag > XMAG_SAT) begin
            xmag = XMAG_SAT;
        end
        prod   = xmag * LOG2E_FX;
        whole  = prod >> 46;
        frac   = (prod & ((64'd1 << 46) - 64'd1)) >> 14;
        red    = (frac * LN2_FX) >> 32;
        term   = 64'd1 << 32;
        series = 64'd1 << 32;
        for (k = 1; k <= SERIES_LEN; k++) begin
            term = ((term * red) >> 32) / 64'(k);
            if (k % 2 == 1) begin
                series = series - term;
            end else begin
                series = series + term;
            end
        end
        ex  = (whole >= 64'd32) ? 64'd0 : series >> whole;
        den = (64'd1 << 32) + ex;
        if (below) begin
            sig = ((ex << 16) + (den >> 1)) / den;
        end else begin
            sig = ((64'd1 << 48) + (den >> 1)) / den;
        end
        q   = 64'd10 * (sig << 16) + K009_FX;
        dep = ((64'd1 << (32 + OUT_FRAC)) + (q >> 1)) / q;
        if (dep > DEPTH_SAT) begin
            dep = DEPTH_SAT;
        end
        return dep[23:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("ERROR %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, results_seen, got, want);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_ZERO_POINT: begin
                zp_model = value[15:0];
            end
            REG_SCALE: begin
                scale_model = value;
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // The upper half of the write data carries junk that the block must ignore.
    task automatic set_zero_point(input logic [15:0] zp);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_ZERO_POINT, {junk[31:16], zp});
    endtask

    task automatic push_pixel(input logic [15:0] code, input logic last);
        pixel_q.insert(pixel_q.size(), pixel_t'{code, last});
    endtask

    // Most codes sit near the zero point so that x lands inside the logistic's knee.
    task automatic push_random(input int count);
        int          i;
        int          off;
        logic [15:0] code;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) < 2) begin
                code = 16'($urandom);
            end else begin
                off  = $urandom_range(0, 1 << $urandom_range(4, 14));
                code = ($urandom_range(0, 1) != 0) ? zp_model + 16'(off)
                                                   : zp_model - 16'(off);
            end
            push_pixel(code, $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pixel_q.size() != 0 || req_held || depth_expect_q.size() != 0);
    endtask

    always @(negedge aclk) begin
        if (aresetn && !req_held) begin
            if (src_gap_left > 0) begin
                src_gap_left--;
            end else if (pixel_q.size() != 0) begin
                offered_px   = pixel_q.pop_front();
                req_held     = 1'b1;
                src_gap_left = src_idle_en ? pick_gap() : 0;
            end
        end
        s_tvalid <= req_held;
        s_tdata  <= offered_px.code;
        s_tlast  <= offered_px.last;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            depth_expect_q.insert(depth_expect_q.size(),
                                  depth_result_t'{predict_depth(s_tdata), s_tlast});
            req_held = 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (snk_stall_left > 0) begin
            snk_stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (snk_idle_en) begin
                snk_stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : result_check
        depth_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (depth_expect_q.size() == 0) begin
                report_mismatch("unexpected result", {8'd0, m_tdata}, 32'd0);
            end else begin
                want = depth_expect_q.pop_front();
                if (m_tdata !== want.depth) begin
                    report_mismatch("depth", {8'd0, m_tdata}, {8'd0, want.depth});
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("tlast", {31'd0, m_tlast}, {31'd0, want.last});
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int          ph;
        logic [31:0] sc;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default scale of 1.0: small positive x, then saturation of the dequantized value.
        set_zero_point(16'h0000);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'h0001, 1'b0);
        push_pixel(16'h0003, 1'b1);
        push_pixel(16'h0008, 1'b0);
        push_pixel(16'h0080, 1'b0);
        push_pixel(16'hFFFF, 1'b1);
        wait_idle();

        // Codes on both sides of the zero point, down to a deep negative x.
        set_zero_point(16'h0040);
        write_reg(REG_SCALE, 32'h0100_0000);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'h0038, 1'b0);
        push_pixel(16'h003F, 1'b0);
        push_pixel(16'h0040, 1'b1);
        push_pixel(16'h0041, 1'b0);
        wait_idle();

        // Largest scale saturates x for any nonzero difference; unmapped writes are dropped.
        set_zero_point(16'h8000);
        write_reg(REG_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_UNMAPPED_2, $urandom);
        write_reg(REG_UNMAPPED_3, $urandom);
        push_pixel(16'h0000, 1'b1);
        push_pixel(16'h7FFF, 1'b0);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'h8001, 1'b0);
        push_pixel(16'hFFFF, 1'b1);
        wait_idle();

        // A zero scale pins x to zero whatever the code.
        set_zero_point(16'hFFFF);
        write_reg(REG_SCALE, 32'd0);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'h1234, 1'b0);
        push_pixel(16'hFFFF, 1'b1);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case ($urandom_range(0, 3))
                0: set_zero_point(16'h0000);
                1: set_zero_point(16'hFFFF);
                default: set_zero_point(16'($urandom));
            endcase
            case ($urandom_range(0, 7))
                0: sc = 32'd0;
                1: sc = 32'hFFFF_FFFF;
                2: sc = 32'h0100_0000;
                3: sc = $urandom;
                default: sc = $urandom_range(64, 1 << 18);
            endcase
            write_reg(REG_SCALE, sc);
            src_idle_en = (ph % 2) == 1;
            snk_idle_en = ((ph / 2) % 2) == 1;
            if (ph == 2) begin
                // The sink holds off long enough for the pipeline to fill and refuse requests.
                src_idle_en   = 1'b0;
                snk_idle_en   = 1'b0;
                long_hold_req = 1'b1;
            end
            if (ph == 5) begin
                push_random(PHASE_ITEMS / 2);
                wait_idle();
                push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                push_random(PHASE_ITEMS);
            end
        end
        wait_idle();
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
